// File: hw/rtl/ubx_command_frame_responder_assert.svh
// ----------------------------------------------------------------------------
// ubx_command_frame_responder_assert.svh
// Assertion shorthands shared by the responder RTL. Each macro expects clk
// and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef UBX_COMMAND_FRAME_RESPONDER_ASSERT_SVH
`define UBX_COMMAND_FRAME_RESPONDER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define UBXCFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define UBXCFR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ubxcfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubxcfr_pkg
// Shared types and constants of the command frame responder.
// ----------------------------------------------------------------------------
package ubxcfr_pkg;

  // Frame framing bytes
  localparam logic [7:0] SYNC_CHAR_1   = 8'hB5;
  localparam logic [7:0] SYNC_CHAR_2   = 8'h62;

  // Request classes and ids
  localparam logic [7:0] CLS_CFG       = 8'h06;
  localparam logic [7:0] CLS_CUSTOM    = 8'hFF;
  localparam logic [7:0] ID_CONFIG     = 8'h27;
  localparam logic [7:0] ID_NACK_LO    = 8'h22;
  localparam logic [7:0] ID_NACK_HI    = 8'h25;
  localparam logic [7:0] ID_ACK_REQ    = 8'h30;

  // Reply classes and ids
  localparam logic [7:0] CLS_ACK       = 8'h05;
  localparam logic [7:0] ID_ACK_ACK    = 8'h01;
  localparam logic [7:0] ID_ACK        = 8'h02;
  localparam logic [7:0] ID_NACK       = 8'h03;
  localparam logic [7:0] CFG_REPLY_B0  = 8'h04;
  localparam logic [7:0] CFG_REPLY_B1  = 8'h00;
  localparam logic [7:0] CFG_REPLY_B2  = 8'h00;

  // Reply frame byte positions
  localparam int unsigned REPLY_IDX_W  = 4;
  localparam logic [REPLY_IDX_W-1:0] LAST_IDX_SHORT = 4'd9;
  localparam logic [REPLY_IDX_W-1:0] LAST_IDX_LONG  = 4'd10;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_write;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
  } reply_item_t;

  // One fully built reply frame waiting for serialization
  typedef struct packed {
    logic [7:0] cls;
    logic [7:0] ident;
    logic       three;   // payload has three bytes, else two
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
  } reply_desc_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } rq_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/ubxcfr_reply_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ubx_command_frame_responder_assert.svh"
// ----------------------------------------------------------------------------
// ubxcfr_reply_queue
// Two-entry queue of built reply frames between parser and serializer.
// ----------------------------------------------------------------------------
module ubxcfr_reply_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire ubxcfr_pkg::reply_desc_t wr_desc,
  input  wire                       pop,
  output ubxcfr_pkg::rq_status_t    status,
  output ubxcfr_pkg::reply_desc_t   head_desc
);
  import ubxcfr_pkg::*;

  reply_desc_t entry_r [0:1];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_desc;
    end
  end

  assign head_desc         = entry_r[rd_ptr_r];
  assign status.full       = count_r[1];
  assign status.head_valid = (count_r != 2'd0);

  `UBXCFR_ASSERT_ALWAYS(a_no_overflow, !(push && count_r[1] && !pop), "reply queue overflow")
  `UBXCFR_ASSERT_ALWAYS(a_no_underflow, !(pop && (count_r == 2'd0)), "reply queue underflow")
  `UBXCFR_ASSERT_ALWAYS(a_count_range, count_r != 2'd3, "reply queue count out of range")

endmodule
`default_nettype wire

// File: hw/rtl/ubxcfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubxcfr_parser
// Byte-wise frame scanner; builds the reply frame when a request completes.
// ----------------------------------------------------------------------------
module ubxcfr_parser #(
  parameter int unsigned MAX_WRITE_BYTES = 64
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         accept,
  input  wire ubxcfr_pkg::rx_item_t   item,
  output logic                        push,
  output ubxcfr_pkg::reply_desc_t     desc
);
  import ubxcfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WRITE_BYTES + 1);

  typedef enum logic [3:0] {
    ST_HUNT, ST_SYNC2, ST_CLASS, ST_IDENT, ST_LENLO,
    ST_LENHI, ST_PAYLD, ST_CKA, ST_CKB
  } scan_t;

  scan_t       state_r, state_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  ident_r, ident_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic        len_zero_r, len_zero_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic        in_window;
  logic [7:0]  b;
  logic [15:0] len_full;
  logic [15:0] remain_dec;
  logic        reply_ok;

  // Fletcher-8 over class, id, length (2 bytes) and two or three payload bytes
  function automatic logic [15:0] fletcher(input reply_desc_t d);
    logic [7:0] bytes [0:6];
    logic [7:0] ca;
    logic [7:0] cb;
    bytes[0] = d.cls;
    bytes[1] = d.ident;
    bytes[2] = d.three ? 8'd3 : 8'd2;
    bytes[3] = 8'h00;
    bytes[4] = d.p0;
    bytes[5] = d.p1;
    bytes[6] = d.p2;
    ca = 8'h00;
    cb = 8'h00;
    for (int i = 0; i < 7; i++) begin
      if (i < 6 || d.three) begin
        ca = ca + bytes[i];
        cb = cb + ca;
      end
    end
    return {ca, cb};
  endfunction

  assign b          = item.rx_byte;
  assign in_window  = (count_r < CNT_W'(MAX_WRITE_BYTES));
  assign len_full   = {b, len_lo_r};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    state_nxt    = state_r;
    class_nxt    = class_r;
    ident_nxt    = ident_r;
    len_lo_nxt   = len_lo_r;
    len_zero_nxt = len_zero_r;
    remain_nxt   = remain_r;
    count_nxt    = count_r;
    if (accept) begin
      if (in_window) begin
        count_nxt = count_r + CNT_W'(1);
        unique case (state_r)
          ST_HUNT: begin
            if (b == SYNC_CHAR_1) state_nxt = ST_SYNC2;
          end
          ST_SYNC2: begin
            if (b == SYNC_CHAR_2)      state_nxt = ST_CLASS;
            else if (b != SYNC_CHAR_1) state_nxt = ST_HUNT;
          end
          ST_CLASS: begin
            class_nxt = b;
            state_nxt = ST_IDENT;
          end
          ST_IDENT: begin
            ident_nxt = b;
            state_nxt = ST_LENLO;
          end
          ST_LENLO: begin
            len_lo_nxt = b;
            state_nxt  = ST_LENHI;
          end
          ST_LENHI: begin
            remain_nxt   = len_full;
            len_zero_nxt = (len_full == 16'd0);
            state_nxt    = (len_full == 16'd0) ? ST_CKA : ST_PAYLD;
          end
          ST_PAYLD: begin
            remain_nxt = remain_dec;
            if (remain_dec == 16'd0) state_nxt = ST_CKA;
          end
          ST_CKA:  state_nxt = ST_CKB;
          ST_CKB:  state_nxt = ST_HUNT;
          default: state_nxt = ST_HUNT;
        endcase
      end
      if (item.end_of_write) begin
        state_nxt = ST_HUNT;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HUNT;
      class_r    <= 8'h00;
      ident_r    <= 8'h00;
      len_lo_r   <= 8'h00;
      len_zero_r <= 1'b1;
      remain_r   <= 16'd0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      class_r    <= class_nxt;
      ident_r    <= ident_nxt;
      len_lo_r   <= len_lo_nxt;
      len_zero_r <= len_zero_nxt;
      remain_r   <= remain_nxt;
      count_r    <= count_nxt;
    end
  end

  // Reply selection
  reply_desc_t d;
  logic [15:0] ck;

  always_comb begin
    reply_ok = 1'b1;
    d.cls    = CLS_CUSTOM;
    d.ident  = ID_NACK;
    d.three  = 1'b0;
    d.p0     = class_r;
    d.p1     = ident_r;
    d.p2     = 8'h00;
    d.ck_a   = 8'h00;
    d.ck_b   = 8'h00;
    if (class_r == CLS_CFG) begin
      d.cls   = CLS_ACK;
      d.ident = ID_ACK_ACK;
    end else if (class_r == CLS_CUSTOM) begin
      if (ident_r == ID_CONFIG) begin
        if (len_zero_r) begin
          d.ident = ID_CONFIG;
          d.three = 1'b1;
          d.p0    = CFG_REPLY_B0;
          d.p1    = CFG_REPLY_B1;
          d.p2    = CFG_REPLY_B2;
        end else begin
          d.ident = ID_ACK;
        end
      end else if (ident_r >= ID_NACK_LO && ident_r <= ID_NACK_HI) begin
        d.ident = ID_NACK;
      end else if (ident_r == ID_ACK_REQ) begin
        d.ident = ID_ACK;
      end else begin
        d.ident = ID_NACK;
      end
    end else begin
      reply_ok = 1'b0;
    end
    ck     = fletcher(d);
    d.ck_a = ck[15:8];
    d.ck_b = ck[7:0];
  end

  assign desc = d;
  assign push = accept && in_window && (state_r == ST_CKB) && reply_ok;

endmodule
`default_nettype wire

// File: hw/rtl/ubxcfr_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ubx_command_frame_responder_assert.svh"
// ----------------------------------------------------------------------------
// ubxcfr_serializer
// Walks the head reply one byte per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module ubxcfr_serializer (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          head_valid,
  input  wire ubxcfr_pkg::reply_desc_t head_desc,
  output logic                         pop,
  output logic                         out_valid,
  input  wire                          out_stall,
  output ubxcfr_pkg::reply_item_t      out_data
);
  import ubxcfr_pkg::*;

  logic [REPLY_IDX_W-1:0] idx_r, idx_nxt;
  logic                   valid_r, valid_nxt;
  reply_item_t            item_r, item_nxt;

  logic [7:0]             frame_b [0:(1 << REPLY_IDX_W) - 1];
  logic [REPLY_IDX_W-1:0] last_idx;
  logic                   load;
  logic                   is_last;

  always_comb begin
    for (int i = 0; i < (1 << REPLY_IDX_W); i++) begin
      frame_b[i] = 8'h00;
    end
    frame_b[0] = SYNC_CHAR_1;
    frame_b[1] = SYNC_CHAR_2;
    frame_b[2] = head_desc.cls;
    frame_b[3] = head_desc.ident;
    frame_b[4] = head_desc.three ? 8'd3 : 8'd2;
    frame_b[5] = 8'h00;
    frame_b[6] = head_desc.p0;
    frame_b[7] = head_desc.p1;
    if (head_desc.three) begin
      frame_b[8]  = head_desc.p2;
      frame_b[9]  = head_desc.ck_a;
      frame_b[10] = head_desc.ck_b;
    end else begin
      frame_b[8] = head_desc.ck_a;
      frame_b[9] = head_desc.ck_b;
    end
  end

  assign last_idx = head_desc.three ? LAST_IDX_LONG : LAST_IDX_SHORT;
  assign is_last  = (idx_r == last_idx);
  assign load     = !valid_r || !out_stall;
  assign pop      = load && head_valid && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        item_nxt.reply_byte = frame_b[idx_r];
        item_nxt.reply_last = is_last;
        idx_nxt = is_last ? '0 : idx_r + REPLY_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = item_r;

  `UBXCFR_ASSERT_IMPLIES(a_idx_idle, !head_valid, idx_r == '0, "byte index left mid-frame")
  `UBXCFR_ASSERT_IMPLIES(a_idx_bound, head_valid, idx_r <= last_idx, "byte index past frame end")

endmodule
`default_nettype wire

// File: hw/rtl/ubx_command_frame_responder.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte that completes a request frame is written into the reply queue, and
//   its reply leaves through the output register once the output is free.
// Throughput: one input and one reply byte per cycle unless stalled; replies
//   are 10 or 11 bytes each, so in_stall rises while two replies are queued.
// Reset: synchronous active-low rst_n clears the scanner to sync hunt, the
//   write byte count, the reply queue and the output valid.
// ----------------------------------------------------------------------------
// ubx_command_frame_responder
// Command frame scanner that answers each complete CFG or custom request
// with an ACK, NACK or config reply frame carrying a Fletcher-8 checksum.
// ----------------------------------------------------------------------------
module ubx_command_frame_responder #(
  parameter int unsigned MAX_WRITE_BYTES = 64
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // received byte transactions
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire ubxcfr_pkg::rx_item_t   in_data,
  // reply byte transactions
  output logic                        out_valid,
  input  wire                         out_stall,
  output ubxcfr_pkg::reply_item_t     out_data
);
  import ubxcfr_pkg::*;

  logic        in_accept;
  logic        push;
  logic        pop;
  reply_desc_t new_desc;
  reply_desc_t head_desc;
  rq_status_t  rq_status;

  // The queue holds whole reply frames; a full queue stalls the input so a
  // completed request never finds no room.
  assign in_stall  = rq_status.full;
  assign in_accept = in_valid && !in_stall;

  // Scanner: each accepted byte below the write limit updates state and reply
  ubxcfr_parser #(
    .MAX_WRITE_BYTES(MAX_WRITE_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .push   (push),
    .desc   (new_desc)
  );

  // Built replies wait here while the serializer drains the previous one
  ubxcfr_reply_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_desc   (new_desc),
    .pop       (pop),
    .status    (rq_status),
    .head_desc (head_desc)
  );

  // Output register: frame bytes in order, last flag on the second checksum
  ubxcfr_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (rq_status.head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: tb/tb_ubx_command_frame_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ubx_command_frame_responder
// Self-checking bench for the command frame responder. Received bytes are
// fed as writes: a short directed table first, then random writes built
// mostly from well-formed request frames with random content. A behavioral
// scanner inside the bench predicts every reply byte, and each reply byte
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ubx_command_frame_responder;
  import ubxcfr_pkg::*;

  localparam int WRITE_LIMIT  = 64;    // bytes a write may carry into the parser
  localparam int RANDOM_BYTES = 100;   // rough size of the random part
  localparam int STALL_LIMIT  = 2000;  // cycles without any transaction
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int IDLE_PCT     = 22;    // idle / stall chance per cycle
  localparam int NUM_PROBES   = 25;

  // Scanner states of the predictor, in the order a frame is read
  typedef enum logic [3:0] {
    SCAN_HUNT, SCAN_SYNC2, SCAN_CLASS, SCAN_IDENT, SCAN_LEN_LO,
    SCAN_LEN_HI, SCAN_BODY, SCAN_CK_A, SCAN_CK_B
  } scan_state_t;

  // One directed row: the byte, its end-of-write mark, and the number of
  // reply bytes it must trigger (-1: left to the predictor alone)
  typedef struct packed {
    logic [7:0] rx;
    logic       eow;
    int         reply_len;
  } probe_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rx_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  reply_item_t out_data;

  // Predictor state
  scan_state_t scan;
  logic [7:0]  req_class;
  logic [7:0]  req_ident;
  logic [15:0] req_len;
  logic [15:0] body_left;
  int          write_count;

  reply_item_t reply_bytes_due [$];   // predicted reply bytes, oldest first
  reply_item_t head_reply;
  logic [7:0]  write_bytes [$];       // bytes of the write being built
  int          mismatch_count;
  int          rand_sent;
  bit          steady;                // no idling on either side
  bit          hold_request;          // asks the receiver for a long hold-off

  // Directed table. Covers: min/max junk bytes while hunting, a repeated
  // sync byte, the empty-payload config query, an ACK-ACK frame whose last
  // checksum byte also ends the write, and a huge length cut by end of write.
  probe_row_t probes [NUM_PROBES] = '{
    '{8'h00, 1'b0,  0}, '{8'hFF, 1'b0,  0},
    '{8'hB5, 1'b0, -1}, '{8'hB5, 1'b0, -1}, '{8'h62, 1'b0, -1},
    '{8'hFF, 1'b0, -1}, '{8'h27, 1'b0, -1}, '{8'h00, 1'b0, -1},
    '{8'h00, 1'b0, -1}, '{8'h5A, 1'b0, -1}, '{8'hA5, 1'b0, 11},
    '{8'hB5, 1'b0, -1}, '{8'h62, 1'b0, -1}, '{8'h06, 1'b0, -1},
    '{8'h01, 1'b0, -1}, '{8'h00, 1'b0, -1}, '{8'h00, 1'b0, -1},
    '{8'h12, 1'b0, -1}, '{8'h34, 1'b1, 10},
    '{8'hB5, 1'b0, -1}, '{8'h62, 1'b0, -1}, '{8'hFF, 1'b0, -1},
    '{8'h30, 1'b0, -1}, '{8'hFF, 1'b0, -1}, '{8'hFF, 1'b1,  0}
  };

  ubx_command_frame_responder #(
    .MAX_WRITE_BYTES(WRITE_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want_v, got_v);
    end
  endtask

  // Queue one reply frame: sync pair, class, id, 16-bit length, payload and
  // the Fletcher-8 pair summed over class through the last payload byte.
  function automatic void frame_reply(input logic [7:0] cls, input logic [7:0] ident,
                                      input logic [7:0] p0, input logic [7:0] p1,
                                      input logic [7:0] p2, input int plen);
    logic [7:0] body [7];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    int         i;
    body[0] = cls;
    body[1] = ident;
    body[2] = plen[7:0];
    body[3] = 8'h00;
    body[4] = p0;
    body[5] = p1;
    body[6] = p2;
    ck_a = 8'h00;
    ck_b = 8'h00;
    reply_bytes_due.push_back(reply_item_t'{SYNC_CHAR_1, 1'b0});
    reply_bytes_due.push_back(reply_item_t'{SYNC_CHAR_2, 1'b0});
    for (i = 0; i < 4 + plen; i++) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
      reply_bytes_due.push_back(reply_item_t'{body[i], 1'b0});
    end
    reply_bytes_due.push_back(reply_item_t'{ck_a, 1'b0});
    reply_bytes_due.push_back(reply_item_t'{ck_b, 1'b1});
  endfunction

  // Reply selection for a finished request frame
  function automatic void answer_request();
    if (req_class == CLS_CFG) begin
      frame_reply(CLS_ACK, ID_ACK_ACK, req_class, req_ident, 8'h00, 2);
    end else if (req_class == CLS_CUSTOM) begin
      if (req_ident == ID_CONFIG) begin
        if (req_len == 16'd0) begin
          frame_reply(CLS_CUSTOM, ID_CONFIG, CFG_REPLY_B0, CFG_REPLY_B1, CFG_REPLY_B2, 3);
        end else begin
          frame_reply(CLS_CUSTOM, ID_ACK, req_class, req_ident, 8'h00, 2);
        end
      end else if (req_ident >= ID_NACK_LO && req_ident <= ID_NACK_HI) begin
        frame_reply(CLS_CUSTOM, ID_NACK, req_class, req_ident, 8'h00, 2);
      end else if (req_ident == ID_ACK_REQ) begin
        frame_reply(CLS_CUSTOM, ID_ACK, req_class, req_ident, 8'h00, 2);
      end else begin
        frame_reply(CLS_CUSTOM, ID_NACK, req_class, req_ident, 8'h00, 2);
      end
    end
  endfunction

  // Advance the predictor by one accepted byte; returns the number of reply
  // bytes that byte triggers.
  function automatic int scan_rx_byte(input rx_item_t item);
    logic [7:0] b;
    int         due_before;
    b = item.rx_byte;
    due_before = reply_bytes_due.size();
    // bytes past the per-write limit never reach the scanner
    if (write_count < WRITE_LIMIT) begin
      write_count++;
      case (scan)
        SCAN_HUNT: begin
          if (b == SYNC_CHAR_1) scan = SCAN_SYNC2;
        end
        SCAN_SYNC2: begin
          // a second B5 keeps waiting for 62
          if (b == SYNC_CHAR_2) scan = SCAN_CLASS;
          else if (b != SYNC_CHAR_1) scan = SCAN_HUNT;
        end
        SCAN_CLASS: begin
          req_class = b;
          scan = SCAN_IDENT;
        end
        SCAN_IDENT: begin
          req_ident = b;
          scan = SCAN_LEN_LO;
        end
        SCAN_LEN_LO: begin
          req_len = {8'h00, b};
          scan = SCAN_LEN_HI;
        end
        SCAN_LEN_HI: begin
          req_len = {b, req_len[7:0]};
          body_left = req_len;
          scan = (req_len == 16'd0) ? SCAN_CK_A : SCAN_BODY;
        end
        SCAN_BODY: begin
          body_left = body_left - 16'd1;
          if (body_left == 16'd0) scan = SCAN_CK_A;
        end
        SCAN_CK_A: begin
          scan = SCAN_CK_B;
        end
        SCAN_CK_B: begin
          answer_request();
          scan = SCAN_HUNT;
        end
        default: begin
          scan = SCAN_HUNT;
        end
      endcase
    end
    // end of write drops any unfinished frame
    if (item.end_of_write) begin
      scan = SCAN_HUNT;
      write_count = 0;
    end
    return reply_bytes_due.size() - due_before;
  endfunction

  // Offer one byte; returns once its transaction is taken, back at a
  // falling edge. Random gaps go in front of the byte, never mid-offer.
  task automatic drive_byte(input logic [7:0] b, input logic eow, output int produced);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rx_item_t'{b, eow};
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    produced = scan_rx_byte(in_data);
    @(negedge clk);
  endtask

  function automatic void add_noise(input int count);
    int i;
    for (i = 0; i < count; i++) write_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Append one request frame with random content. Returns 1 when the frame
  // carries a length too large to finish, so the write should end there.
  function automatic bit add_frame(input bit truncate);
    logic [7:0]  fr [$];
    logic [7:0]  cls;
    logic [7:0]  ident;
    logic [15:0] len;
    bit          huge;
    int          pick;
    int          i;
    int          cut;
    pick = $urandom_range(9);
    if (pick < 4) cls = CLS_CUSTOM;
    else if (pick < 7) cls = CLS_CFG;
    else cls = 8'($urandom_range(255));
    case ($urandom_range(7))
      0: ident = ID_CONFIG;
      1: ident = ID_NACK_LO + 8'($urandom_range(3));
      2: ident = ID_ACK_REQ;
      3: ident = ID_NACK_LO - 8'd1;
      4: ident = ID_NACK_HI + 8'd1;
      default: ident = 8'($urandom_range(255));
    endcase
    huge = ($urandom_range(11) == 0);
    len = huge ? 16'($urandom_range(65535)) : 16'($urandom_range(4));
    fr.push_back(SYNC_CHAR_1);
    if ($urandom_range(5) == 0) fr.push_back(SYNC_CHAR_1);
    fr.push_back(SYNC_CHAR_2);
    fr.push_back(cls);
    fr.push_back(ident);
    fr.push_back(len[7:0]);
    fr.push_back(len[15:8]);
    if (huge) begin
      for (i = 0; i < $urandom_range(6); i++) fr.push_back(8'($urandom_range(255)));
    end else begin
      // payload plus the two checksum bytes, which the block never checks
      for (i = 0; i < len + 2; i++) fr.push_back(8'($urandom_range(255)));
    end
    if (truncate) begin
      cut = 1 + $urandom_range(fr.size() - 2);
      while (fr.size() > cut) void'(fr.pop_back());
    end
    foreach (fr[k]) write_bytes.push_back(fr[k]);
    return huge;
  endfunction

  // Build and send one random write. Mostly well-formed frames with noise
  // between them; now and then a broken last frame, a noise-only write, or
  // an overlong write whose tail the parser must ignore.
  task automatic send_random_write(input bit overlong);
    int frames;
    int i;
    int produced;
    bit open_ended;
    write_bytes.delete();
    open_ended = 1'b0;
    if ($urandom_range(14) == 0) begin
      add_noise(1 + $urandom_range(8));
    end else begin
      frames = 1 + $urandom_range(2);
      for (i = 0; i < frames && !open_ended; i++) begin
        add_noise($urandom_range(3));
        open_ended = add_frame(i == frames - 1 && $urandom_range(9) == 0);
      end
    end
    if (overlong) begin
      while (write_bytes.size() < WRITE_LIMIT + 8) begin
        add_noise($urandom_range(2));
        void'(add_frame(1'b0));
      end
    end
    foreach (write_bytes[j]) begin
      drive_byte(write_bytes[j], j == write_bytes.size() - 1, produced);
      rand_sent++;
    end
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off that
  // it counts itself so the block backs up into in_stall.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Reply checker: every reply byte transaction must match the oldest
  // prediction in both fields.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reply_bytes_due.size() == 0) begin
        report_mismatch("reply byte with none predicted", 16'h0, {7'h0, out_data});
      end else begin
        head_reply = reply_bytes_due.pop_front();
        if (out_data.reply_byte !== head_reply.reply_byte) begin
          report_mismatch("reply_byte", 16'(head_reply.reply_byte),
                          16'(out_data.reply_byte));
        end
        if (out_data.reply_last !== head_reply.reply_last) begin
          report_mismatch("reply_last", 16'(head_reply.reply_last),
                          16'(out_data.reply_last));
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for
  // too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence
  initial begin
    int row;
    int produced;
    int writes;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    steady         = 1'b0;
    hold_request   = 1'b0;
    mismatch_count = 0;
    rand_sent      = 0;
    scan           = SCAN_HUNT;
    req_class      = 8'h00;
    req_ident      = 8'h00;
    req_len        = 16'h0;
    body_left      = 16'h0;
    write_count    = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; rows with a typed reply length are held to it too
    for (row = 0; row < NUM_PROBES; row++) begin
      drive_byte(probes[row].rx, probes[row].eow, produced);
      if (probes[row].reply_len >= 0 && produced != probes[row].reply_len) begin
        report_mismatch("directed reply length", 16'(probes[row].reply_len),
                        16'(produced));
      end
    end

    // Sender pause: let every predicted reply drain before going on
    in_valid <= 1'b0;
    while (reply_bytes_due.size() != 0) @(posedge clk);
    @(negedge clk);

    // Random writes: the first one overlong and sent under a long receiver
    // hold-off, then writes 1-2 with no idling on either side.
    writes = 0;
    while (rand_sent < RANDOM_BYTES || writes < 3) begin
      steady = (writes >= 1 && writes <= 2);
      if (writes == 0) hold_request = 1'b1;
      send_random_write(writes == 0);
      writes++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then a short tail to catch stray reply bytes
    while (reply_bytes_due.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
